// ===== rtl/sfm_pkg.sv =====
// Shared types and constants for the substring first-match search block.
package sfm_pkg;

   localparam int MAX_PATTERN = 16;
   localparam int MAX_TEXT    = 4096;

   localparam int BYTE_W = 8;
   localparam int POS_W  = 12;
   localparam int LEN_W  = $clog2(MAX_PATTERN + 1);
   localparam int CNT_MAX = MAX_TEXT + MAX_PATTERN;
   localparam int CNT_W  = $clog2(CNT_MAX + 1);

   localparam logic OP_PATTERN = 1'b0;
   localparam logic OP_TEXT    = 1'b1;

   typedef enum logic [1:0] {
      STATUS_FOUND     = 2'd0,
      STATUS_NOT_FOUND = 2'd1,
      STATUS_TOO_LONG  = 2'd2
   } status_type;

   typedef struct packed {
      logic               operation;
      logic [BYTE_W-1:0]  data_byte;
      logic               last_byte;
   } req_type;

   typedef struct packed {
      status_type         status;
      logic [POS_W-1:0]   match_position;
   } rsp_type;

   typedef struct packed {
      logic load_pat;
      logic shift_text;
      logic clear;
   } cell_ctl_type;

endpackage

// ===== rtl/sfm_cell.sv =====
// One compare cell: holds a pattern byte and a text byte, both shifting to the next cell.
module sfm_cell (
   input  logic                        clock,
   input  logic                        reset,
   input  sfm_pkg::cell_ctl_type       ctl,
   input  logic [sfm_pkg::BYTE_W-1:0]  pat_in,
   input  logic                        valid_in,
   input  logic [sfm_pkg::BYTE_W-1:0]  win_in,
   output logic [sfm_pkg::BYTE_W-1:0]  pat_out,
   output logic                        valid_out,
   output logic [sfm_pkg::BYTE_W-1:0]  win_out,
   output logic                        eq_out
);

   logic [sfm_pkg::BYTE_W-1:0] pattern_ff;
   logic [sfm_pkg::BYTE_W-1:0] pattern_in;
   logic [sfm_pkg::BYTE_W-1:0] window_ff;
   logic [sfm_pkg::BYTE_W-1:0] window_in;
   logic                       valid_ff;
   logic                       valid_in_nxt;

   always_comb begin
      pattern_in   = ctl.load_pat ? pat_in : pattern_ff;
      window_in    = ctl.shift_text ? win_in : window_ff;
      valid_in_nxt = valid_ff;
      if (ctl.clear) begin
         valid_in_nxt = 1'b0;
      end else if (ctl.load_pat) begin
         valid_in_nxt = valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pattern_ff <= pattern_in;
      window_ff  <= window_in;
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in_nxt;
      end
   end

   // compare the byte arriving this beat against the held pattern byte
   assign eq_out    = !valid_ff || (win_in == pattern_ff);
   assign pat_out   = pattern_ff;
   assign valid_out = valid_ff;
   assign win_out   = window_ff;

endmodule

// ===== rtl/substring_first_match.sv =====
// Top level of the substring first-match search block.
//
// Request channel (req_valid/req_ready, req): operation selects a pattern
// byte load or a text byte. Pattern bytes are loaded first; text bytes then
// stream in. The text beat with last_byte set closes the job and produces
// one result beat on the rsp channel with status and match_position.
// Pattern and text beats are taken one per cycle but for the stall below.
// The newest pattern byte and newest text byte enter cell 0 of a row of
// MAX_PATTERN compare cells and shift one cell per beat; all cells compare
// in parallel on the beat that brings in a text byte.
// The result is registered and appears in the cycle after the last
// text beat is accepted. After the result all job state clears, so the
// next pattern may follow in the next cycle.
// When the receiver stalls, the pending result holds; pattern and text beats
// keep being accepted, and only a beat that would close another job waits.
// Reset (synchronous, active high) clears the job state and the result valid.
module substring_first_match (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  sfm_pkg::req_type  req,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output sfm_pkg::rsp_type  rsp
);

   localparam int N = sfm_pkg::MAX_PATTERN;

   logic [sfm_pkg::LEN_W-1:0] len_ff, len_in;
   logic                      too_long_ff, too_long_in;
   logic [sfm_pkg::CNT_W-1:0] count_ff, count_in;
   logic                      seen_ff, seen_in;
   logic [sfm_pkg::POS_W-1:0] first_idx_ff, first_idx_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   sfm_pkg::rsp_type          rsp_ff, rsp_in;

   sfm_pkg::cell_ctl_type     ctl;
   logic                      accept;
   logic                      is_text;
   logic                      closes;
   logic                      hit;
   logic [sfm_pkg::CNT_W-1:0] start;

   logic [N-1:0]                    eq_vec;
   logic [N:0]                      valid_chain;
   logic [sfm_pkg::BYTE_W-1:0]      pat_chain [N+1];
   logic [sfm_pkg::BYTE_W-1:0]      win_chain [N+1];

   // hold off only a closing beat while a result is still stalled
   assign closes    = (req.operation == sfm_pkg::OP_TEXT) && req.last_byte;
   assign req_ready = !(rsp_valid_ff && !rsp_ready && req_valid && closes);
   assign accept    = req_valid && req_ready;
   assign is_text   = req.operation == sfm_pkg::OP_TEXT;

   always_comb begin
      ctl.load_pat   = accept && !is_text && (len_ff < sfm_pkg::LEN_W'(N));
      ctl.shift_text = accept && is_text;
      ctl.clear      = accept && closes;
   end

   assign pat_chain[0]   = req.data_byte;
   assign win_chain[0]   = req.data_byte;
   assign valid_chain[0] = 1'b1;

   for (genvar k = 0; k < N; k++) begin : g_cell
      sfm_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .ctl       (ctl),
         .pat_in    (pat_chain[k]),
         .valid_in  (valid_chain[k]),
         .win_in    (win_chain[k]),
         .pat_out   (pat_chain[k+1]),
         .valid_out (valid_chain[k+1]),
         .win_out   (win_chain[k+1]),
         .eq_out    (eq_vec[k])
      );
   end

   always_comb begin
      len_in       = len_ff;
      too_long_in  = too_long_ff;
      count_in     = count_ff;
      seen_in      = seen_ff;
      first_idx_in = first_idx_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_in       = rsp_ff;
      hit          = 1'b0;
      start        = '0;

      if (accept && !is_text) begin
         if (ctl.load_pat) begin
            len_in = len_ff + 1'b1;
         end else begin
            too_long_in = 1'b1;
         end
      end

      if (ctl.shift_text) begin
         if (count_ff < sfm_pkg::CNT_W'(sfm_pkg::CNT_MAX)) begin
            count_in = count_ff + 1'b1;
         end
         start = count_in - sfm_pkg::CNT_W'(len_ff);
         hit   = !seen_ff && !too_long_ff && (len_ff != '0)
                 && (count_in >= sfm_pkg::CNT_W'(len_ff))
                 && (start < sfm_pkg::CNT_W'(sfm_pkg::MAX_TEXT))
                 && (&eq_vec);
         if (hit) begin
            seen_in      = 1'b1;
            first_idx_in = start[sfm_pkg::POS_W-1:0];
         end
      end

      if (ctl.clear) begin
         rsp_valid_in = 1'b1;
         if (too_long_ff) begin
            rsp_in.status         = sfm_pkg::STATUS_TOO_LONG;
            rsp_in.match_position = '0;
         end else if (seen_in) begin
            rsp_in.status         = sfm_pkg::STATUS_FOUND;
            rsp_in.match_position = first_idx_in;
         end else begin
            rsp_in.status         = sfm_pkg::STATUS_NOT_FOUND;
            rsp_in.match_position = '0;
         end
         len_in       = '0;
         too_long_in  = 1'b0;
         count_in     = '0;
         seen_in      = 1'b0;
         first_idx_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
      if (reset) begin
         len_ff       <= '0;
         too_long_ff  <= 1'b0;
         count_ff     <= '0;
         seen_ff      <= 1'b0;
         first_idx_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         len_ff       <= len_in;
         too_long_ff  <= too_long_in;
         count_ff     <= count_in;
         seen_ff      <= seen_in;
         first_idx_ff <= first_idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

endmodule

// ===== rtl/sfm_checker.sv =====
// Port-level checks for the substring first-match search block, bound to the top level.
module sfm_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_ready,
   input sfm_pkg::req_type  req,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input sfm_pkg::rsp_type  rsp
);

   // a stalled result beat stays up
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result beat dropped while stalled");

   // a fresh result follows only a closing text beat
   a_rsp_cause: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_valid && req_ready
                                 && req.operation == sfm_pkg::OP_TEXT && req.last_byte))
      else $error("result without a closing text beat");

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp.status == sfm_pkg::STATUS_FOUND
                     || rsp.status == sfm_pkg::STATUS_NOT_FOUND
                     || rsp.status == sfm_pkg::STATUS_TOO_LONG))
      else $error("undefined status code");

   a_pos_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp.status != sfm_pkg::STATUS_FOUND |-> rsp.match_position == '0)
      else $error("position nonzero without a match");

endmodule

bind substring_first_match sfm_checker u_sfm_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .req       (req),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp       (rsp)
);
